[design/tga_pkg.sv]
// Package for the TGA stream decoder: request payload types, result kinds,
// error codes, parser phases and header constants. No dependencies.
`default_nettype none

package tga_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_RAWPIX = 3'd2,
    PH_PKTHDR = 3'd3,
    PH_PKTPIX = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_TYPE   = 2'd1,
    ERR_BAD_DEPTH  = 2'd2,
    ERR_ZERO_DIM   = 2'd3
  } err_e;

  // Header layout.
  localparam int unsigned PatternLen  = 12;
  localparam logic [4:0]  HdrWidthLo  = 5'd12;
  localparam logic [4:0]  HdrWidthHi  = 5'd13;
  localparam logic [4:0]  HdrHeightLo = 5'd14;
  localparam logic [4:0]  HdrHeightHi = 5'd15;
  localparam logic [4:0]  HdrDepth    = 5'd16;
  localparam logic [4:0]  HdrLast     = 5'd17;

  localparam logic [7:0] PatternRaw [PatternLen] =
    '{8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] PatternRle [PatternLen] =
    '{8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam logic [7:0] Depth24    = 8'd24;
  localparam logic [7:0] Depth32    = 8'd32;
  localparam logic [7:0] RunFlag    = 8'd128;
  localparam logic [7:0] RunOffset  = 8'd127;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic        is_compressed;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic        last_pixel;
    err_e        error_code;
  } out_t;

endpackage

`default_nettype wire

[design/tga_stream_if.sv]
// Valid/ready channel interfaces for the TGA stream decoder.
// Depends on tga_pkg for the payload types.
`default_nettype none

interface tga_in_if import tga_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tga_out_if import tga_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/tga_rle_stream_decoder.sv]
// TGA stream decoder: one file byte per request, at most one result per byte.
// A result is registered and presented in the cycle after the byte that causes it.
// Throughput: one byte per cycle, set by the single result register, which
// stalls input only while it holds a result that is not taken.
// Reset (rst_ni low, asynchronous) returns the parser to idle, where bytes
// are ignored until one arrives with start_of_file set.
`default_nettype none

module tga_rle_stream_decoder import tga_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tga_in_if.sink     in_i,
  tga_out_if.source  out_o
);

  // Parser state. The colour buffer holds the blue, green and red bytes of
  // the pixel being gathered, blue in the low byte.
  phase_e      phase_q, phase_d;
  logic [4:0]  hdr_idx_q, hdr_idx_d;
  logic        ok_raw_q, ok_raw_d;
  logic        ok_rle_q, ok_rle_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        alpha_mode_q, alpha_mode_d;
  logic        depth_ok_q, depth_ok_d;
  logic [31:0] pix_left_q, pix_left_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic        pkt_run_q, pkt_run_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [23:0] colour_q, colour_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  out_t        out_data_q, out_data_d;

  logic        in_accept;
  logic        res_valid;
  out_t        res;
  logic [7:0]  b;
  logic        pix_done;
  logic [7:0]  pix_alpha;
  logic [7:0]  pix_count;
  logic [31:0] pix_rem;
  logic [1:0]  byte_need;

  // The result register is freed either by being empty or by being taken in
  // this cycle, so a new byte can follow every cycle.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_accept   = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;
  assign b           = in_i.data.data_byte;

  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    ok_raw_d     = ok_raw_q;
    ok_rle_d     = ok_rle_q;
    width_d      = width_q;
    height_d     = height_q;
    alpha_mode_d = alpha_mode_q;
    depth_ok_d   = depth_ok_q;
    pix_left_d   = pix_left_q;
    pkt_left_d   = pkt_left_q;
    pkt_run_d    = pkt_run_q;
    byte_idx_d   = byte_idx_q;
    colour_d     = colour_q;
    res          = '0;
    res_valid    = 1'b0;
    pix_done     = 1'b0;
    pix_alpha    = 8'd0;
    pix_count    = 8'd1;
    pix_rem      = 32'd0;
    byte_need    = 2'd0;

    // A start byte throws away whatever parse was in progress and becomes
    // header byte zero of a fresh file.
    if (in_i.data.start_of_file) begin
      phase_d      = PH_HEADER;
      hdr_idx_d    = 5'd0;
      ok_raw_d     = 1'b1;
      ok_rle_d     = 1'b1;
      width_d      = 16'd0;
      height_d     = 16'd0;
      alpha_mode_d = 1'b0;
      depth_ok_d   = 1'b0;
      pix_left_d   = 32'd0;
      pkt_left_d   = 8'd0;
      pkt_run_d    = 1'b0;
      byte_idx_d   = 2'd0;
      colour_d     = 24'd0;
    end

    // Pixel byte gathering, used by both pixel phases. A 32-bit pixel ends
    // on its fourth byte (the alpha), a 24-bit one on its third (the red).
    byte_need = alpha_mode_d ? 2'd0 : 2'd3;
    if (phase_d == PH_RAWPIX || phase_d == PH_PKTPIX) begin
      case (byte_idx_d)
        2'd0:    colour_d[7:0]   = b;
        2'd1:    colour_d[15:8]  = b;
        2'd2:    colour_d[23:16] = b;
        default: pix_alpha       = b;
      endcase
      pix_done   = (byte_idx_d + 2'd1) == byte_need;
      byte_idx_d = pix_done ? 2'd0 : byte_idx_d + 2'd1;
    end

    case (phase_d)
      PH_HEADER: begin
        case (hdr_idx_d) inside
          [5'd0:5'd11]: begin
            if (b != PatternRaw[hdr_idx_d[3:0]]) ok_raw_d = 1'b0;
            if (b != PatternRle[hdr_idx_d[3:0]]) ok_rle_d = 1'b0;
          end
          HdrWidthLo:  width_d[7:0]   = b;
          HdrWidthHi:  width_d[15:8]  = b;
          HdrHeightLo: height_d[7:0]  = b;
          HdrHeightHi: height_d[15:8] = b;
          HdrDepth: begin
            depth_ok_d   = (b == Depth24) || (b == Depth32);
            alpha_mode_d = (b == Depth32);
          end
          default: begin
            // Last header byte: checks in priority order, zero dimension
            // first, then depth, then file type.
            res_valid = 1'b1;
            if (width_d == 16'd0 || height_d == 16'd0) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_ZERO_DIM;
              phase_d        = PH_DONE;
            end else if (!depth_ok_d) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_DEPTH;
              phase_d        = PH_DONE;
            end else if (!ok_raw_d && !ok_rle_d) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_TYPE;
              phase_d        = PH_DONE;
            end else begin
              pix_left_d        = {16'd0, width_d} * {16'd0, height_d};
              byte_idx_d        = 2'd0;
              pkt_left_d        = 8'd0;
              pkt_run_d         = 1'b0;
              phase_d           = ok_rle_d ? PH_PKTHDR : PH_RAWPIX;
              res.kind          = KIND_HEADER;
              res.image_width   = width_d;
              res.image_height  = height_d;
              res.has_alpha     = alpha_mode_d;
              res.is_compressed = ok_rle_d;
            end
          end
        endcase
        if (!res_valid) hdr_idx_d = hdr_idx_d + 5'd1;
      end
      PH_RAWPIX: begin
        res_valid = pix_done;
      end
      PH_PKTHDR: begin
        // Packet header: high bit marks a run, low bits hold count minus one.
        if (b < RunFlag) begin
          pkt_run_d  = 1'b0;
          pkt_left_d = b + 8'd1;
        end else begin
          pkt_run_d  = 1'b1;
          pkt_left_d = b - RunOffset;
        end
        byte_idx_d = 2'd0;
        phase_d    = PH_PKTPIX;
      end
      PH_PKTPIX: begin
        if (pix_done) begin
          res_valid = 1'b1;
          if (pkt_run_d) begin
            // A run reaching past the image end is clipped to what remains.
            if ({24'd0, pkt_left_d} > pix_left_d) pix_count = pix_left_d[7:0];
            else pix_count = pkt_left_d;
            pkt_left_d = 8'd0;
            phase_d    = PH_PKTHDR;
          end else begin
            pkt_left_d = pkt_left_d - 8'd1;
            if (pkt_left_d == 8'd0) phase_d = PH_PKTHDR;
          end
        end
      end
      default: ;
    endcase

    // Common pixel result, including the end-of-image check.
    if (res_valid && (phase_q == PH_RAWPIX || phase_q == PH_PKTPIX ||
                      in_i.data.start_of_file) &&
        (phase_d == PH_RAWPIX || phase_d == PH_PKTPIX || phase_d == PH_PKTHDR) &&
        pix_done) begin
      pix_rem        = pix_left_d - {24'd0, pix_count};
      pix_left_d     = pix_rem;
      res.kind       = KIND_PIXEL;
      res.red        = colour_d[23:16];
      res.green      = colour_d[15:8];
      res.blue       = colour_d[7:0];
      res.alpha      = alpha_mode_d ? pix_alpha : 8'd0;
      res.repeat_res = pix_count;
      res.last_pixel = (pix_rem == 32'd0);
      if (pix_rem == 32'd0) phase_d = PH_DONE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_accept) begin
      out_valid_d = res_valid;
      out_data_d  = res;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      hdr_idx_q    <= 5'd0;
      ok_raw_q     <= 1'b1;
      ok_rle_q     <= 1'b1;
      width_q      <= 16'd0;
      height_q     <= 16'd0;
      alpha_mode_q <= 1'b0;
      depth_ok_q   <= 1'b0;
      pix_left_q   <= 32'd0;
      pkt_left_q   <= 8'd0;
      pkt_run_q    <= 1'b0;
      byte_idx_q   <= 2'd0;
      colour_q     <= 24'd0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        phase_q      <= phase_d;
        hdr_idx_q    <= hdr_idx_d;
        ok_raw_q     <= ok_raw_d;
        ok_rle_q     <= ok_rle_d;
        width_q      <= width_d;
        height_q     <= height_d;
        alpha_mode_q <= alpha_mode_d;
        depth_ok_q   <= depth_ok_d;
        pix_left_q   <= pix_left_d;
        pkt_left_q   <= pkt_left_d;
        pkt_run_q    <= pkt_run_d;
        byte_idx_q   <= byte_idx_d;
        colour_q     <= colour_d;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire
